FILE: rtl/core/acp_pkg.sv
`default_nettype none
package acp_pkg;

    // Vector components carry 20 fraction bits and enough headroom for CORDIC growth.
    localparam int VEC_W = 50;
    localparam int FRAC_BITS = 20;
    localparam int ANG_W = 32;
    localparam int DEF_CORDIC_STAGES = 16;
    localparam int TAB_LEN = 24;
    localparam logic signed [17:0] GAIN_S = 18'sd39797;
    localparam logic [16:0] GAIN_U = 17'd39797;
    localparam logic [14:0] DEG64_TURN = 15'd23040;

    localparam logic [1:0] CFG_IGNORE_HEADING = 2'd0;
    localparam logic [1:0] CFG_IGNORE_ATTITUDE = 2'd1;

    function automatic logic [ANG_W-1:0] atan_tab(input int idx);
        logic [ANG_W-1:0] v;
        case (idx)
            0: v = 32'h20000000;
            1: v = 32'h12E4051E;
            2: v = 32'h09FB385B;
            3: v = 32'h051111D4;
            4: v = 32'h028B0D43;
            5: v = 32'h0145D7E1;
            6: v = 32'h00A2F61E;
            7: v = 32'h00517C55;
            8: v = 32'h0028BE53;
            9: v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/acp_cordic.sv
`default_nettype none
module acp_cordic #(
    parameter int STAGES = acp_pkg::DEF_CORDIC_STAGES,
    parameter bit VECT = 1'b0,
    parameter int SW = 1
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_vld,
    input  wire logic signed [acp_pkg::VEC_W-1:0]  i_x,
    input  wire logic signed [acp_pkg::VEC_W-1:0]  i_y,
    input  wire logic [acp_pkg::ANG_W-1:0]         i_z,
    input  wire logic [SW-1:0]                     i_side,
    output logic                                   o_vld,
    output logic signed [acp_pkg::VEC_W-1:0]       o_x,
    output logic signed [acp_pkg::VEC_W-1:0]       o_y,
    output logic [acp_pkg::ANG_W-1:0]              o_z,
    output logic [SW-1:0]                          o_side
);
    localparam int W = acp_pkg::VEC_W;
    localparam int HW = W - 24 + 18;
    localparam int SUMW = W + 18;

    typedef logic signed [W-1:0] t_vec;
    typedef logic [acp_pkg::ANG_W-1:0] t_ang;
    typedef logic signed [HW-1:0] t_hi;
    typedef logic [40:0] t_lo;
    typedef logic signed [SUMW-1:0] t_sum;

    t_vec r_x [0:STAGES];
    t_vec r_y [0:STAGES];
    t_ang r_z [0:STAGES];
    logic [SW-1:0] r_side [0:STAGES];
    logic r_zero [0:STAGES];
    logic r_vld [0:STAGES];

    t_vec n_x0, n_y0;
    t_ang n_z0, z_half;
    logic n_zero0;

    // Pre-rotation into the CORDIC convergence range.
    always_comb begin
        n_x0 = i_x;
        n_y0 = i_y;
        n_z0 = i_z;
        n_zero0 = 1'b0;
        z_half = i_z + 32'h4000_0000;
        if (VECT) begin
            n_z0 = '0;
            n_zero0 = (i_x == '0) && (i_y == '0);
            if (i_x[W-1]) begin
                if (!i_y[W-1]) begin
                    n_x0 = i_y;
                    n_y0 = -i_x;
                    n_z0 = 32'h4000_0000;
                end else begin
                    n_x0 = -i_y;
                    n_y0 = i_x;
                    n_z0 = 32'hC000_0000;
                end
            end
        end else if (z_half[31]) begin
            n_x0 = -i_x;
            n_y0 = -i_y;
            n_z0 = i_z + 32'h8000_0000;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0] <= n_x0;
        r_y[0] <= n_y0;
        r_z[0] <= n_z0;
        r_zero[0] <= n_zero0;
        r_side[0] <= i_side;
    end

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        t_vec xs, ys;
        logic up;
        always_comb begin
            xs = r_x[s] >>> s;
            ys = r_y[s] >>> s;
            up = VECT ? !r_y[s][W-1] : r_z[s][31];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= r_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (up) begin
                r_x[s+1] <= r_x[s] + ys;
                r_y[s+1] <= r_y[s] - xs;
                r_z[s+1] <= r_z[s] + acp_pkg::atan_tab(s);
            end else begin
                r_x[s+1] <= r_x[s] - ys;
                r_y[s+1] <= r_y[s] + xs;
                r_z[s+1] <= r_z[s] - acp_pkg::atan_tab(s);
            end
            r_zero[s+1] <= r_zero[s];
            r_side[s+1] <= r_side[s];
        end
    end

    // Gain compensation: the product is split into a high and a low partial product.
    t_hi r_phx, r_phy;
    t_lo r_plx, r_ply;
    t_ang r_zc;
    logic r_zeroc, r_vldc;
    logic [SW-1:0] r_sidec;
    t_sum n_sx, n_sy;
    t_vec r_ox, r_oy;
    t_ang r_oz;
    logic r_ovld;
    logic [SW-1:0] r_oside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vldc <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            r_vldc <= r_vld[STAGES];
            r_ovld <= r_vldc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phx <= $signed(r_x[STAGES][W-1:24]) * acp_pkg::GAIN_S;
        r_phy <= $signed(r_y[STAGES][W-1:24]) * acp_pkg::GAIN_S;
        r_plx <= r_x[STAGES][23:0] * acp_pkg::GAIN_U;
        r_ply <= r_y[STAGES][23:0] * acp_pkg::GAIN_U;
        r_zc <= r_z[STAGES];
        r_zeroc <= r_zero[STAGES];
        r_sidec <= r_side[STAGES];
    end

    always_comb begin
        n_sx = t_sum'({r_phx, 24'b0}) + t_sum'({1'b0, r_plx});
        n_sy = t_sum'({r_phy, 24'b0}) + t_sum'({1'b0, r_ply});
    end

    always_ff @(posedge i_clk) begin
        if (r_zeroc) begin
            r_ox <= '0;
            r_oz <= '0;
        end else begin
            r_ox <= n_sx[W+15:16];
            r_oz <= r_zc;
        end
        r_oy <= n_sy[W+15:16];
        r_oside <= r_sidec;
    end

    assign o_vld = r_ovld;
    assign o_x = r_ox;
    assign o_y = r_oy;
    assign o_z = r_oz;
    assign o_side = r_oside;

endmodule
`default_nettype wire

FILE: rtl/core/antenna_pan_tilt_pointing.sv
`default_nettype none
// Channel    | Direction | Signals                                   | Handshake
// command    | in        | i_own_*, i_*_ang, i_target_*              | start, busy
// result     | out       | o_pan_deg, o_tilt_deg                     | o_valid strobe
// config     | in        | i_cfg_index, i_cfg_data                   | i_cfg_valid, o_cfg_ready
//
// One item is accepted every cycle; busy is always low.
// Each item passes through three rotation pipelines and two vectoring
// pipelines in series.
// Synchronous active-low reset clears the valid bits and the two config bits.
// The result receiver cannot stall, so the pipeline never holds.
module antenna_pan_tilt_pointing #(
    parameter int CORDIC_STAGES = acp_pkg::DEF_CORDIC_STAGES
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [23:0] i_own_east,
    input  wire logic signed [23:0] i_own_north,
    input  wire logic signed [23:0] i_own_alt,
    input  wire logic signed [15:0] i_roll_ang,
    input  wire logic signed [15:0] i_pitch_ang,
    input  wire logic signed [15:0] i_yaw_ang,
    input  wire logic signed [23:0] i_target_east,
    input  wire logic signed [23:0] i_target_north,
    input  wire logic signed [23:0] i_target_alt,
    output logic                    o_valid,
    output logic [14:0]             o_pan_deg,
    output logic [14:0]             o_tilt_deg,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic               i_cfg_data
);
    localparam int W = acp_pkg::VEC_W;
    localparam int AW = acp_pkg::ANG_W;
    localparam int LAT = 5 * (CORDIC_STAGES + 3) + 3;

    typedef logic signed [W-1:0] t_vec;
    typedef logic [AW-1:0] t_ang;

    logic r_ign_head, r_ign_att;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ign_head <= 1'b0;
            r_ign_att <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == acp_pkg::CFG_IGNORE_HEADING) begin
                r_ign_head <= i_cfg_data;
            end
            if (i_cfg_index == acp_pkg::CFG_IGNORE_ATTITUDE) begin
                r_ign_att <= i_cfg_data;
            end
        end
    end

    assign o_cfg_ready = 1'b1;
    assign busy = 1'b0;

    // Input stage: difference vector in fixed point and the three angles.
    logic signed [24:0] d_e, d_n, d_u;
    t_vec r_e0, r_n0, r_u0;
    t_ang r_yaw0, r_pitch0, r_roll0;
    logic r_vld0;

    always_comb begin
        d_e = 25'(i_target_east) - 25'(i_own_east);
        d_n = 25'(i_target_north) - 25'(i_own_north);
        d_u = 25'(i_target_alt) - 25'(i_own_alt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else begin
            r_vld0 <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e0 <= {{(W - 25 - acp_pkg::FRAC_BITS){d_e[24]}}, d_e, {acp_pkg::FRAC_BITS{1'b0}}};
        r_n0 <= {{(W - 25 - acp_pkg::FRAC_BITS){d_n[24]}}, d_n, {acp_pkg::FRAC_BITS{1'b0}}};
        r_u0 <= {{(W - 25 - acp_pkg::FRAC_BITS){d_u[24]}}, d_u, {acp_pkg::FRAC_BITS{1'b0}}};
        r_yaw0 <= r_ign_head ? '0 : t_ang'(0) - {i_yaw_ang, 16'b0};
        r_pitch0 <= r_ign_att ? '0 : t_ang'(0) - {i_pitch_ang, 16'b0};
        r_roll0 <= r_ign_att ? '0 : {i_roll_ang, 16'b0};
    end

    // Yaw on (north, east).
    logic v1;
    t_vec n1, e1, u1;
    t_ang p1, rl1;
    t_ang z1;
    acp_cordic #(.STAGES(CORDIC_STAGES), .VECT(1'b0), .SW(W + 2 * AW)) u_yaw (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_vld0),
        .i_x(r_n0), .i_y(r_e0), .i_z(r_yaw0), .i_side({r_u0, r_pitch0, r_roll0}),
        .o_vld(v1), .o_x(n1), .o_y(e1), .o_z(z1), .o_side({u1, p1, rl1})
    );

    // Pitch on (north, up).
    logic v2;
    t_vec n2, u2, e2;
    t_ang rl2, z2;
    acp_cordic #(.STAGES(CORDIC_STAGES), .VECT(1'b0), .SW(W + AW)) u_pitch (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(v1),
        .i_x(n1), .i_y(u1), .i_z(p1), .i_side({e1, rl1}),
        .o_vld(v2), .o_x(n2), .o_y(u2), .o_z(z2), .o_side({e2, rl2})
    );

    // Roll on (east, up).
    logic v3;
    t_vec e3, u3, n3;
    t_ang z3;
    acp_cordic #(.STAGES(CORDIC_STAGES), .VECT(1'b0), .SW(W)) u_roll (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(v2),
        .i_x(e2), .i_y(u2), .i_z(rl2), .i_side(n2),
        .o_vld(v3), .o_x(e3), .o_y(u3), .o_z(z3), .o_side(n3)
    );

    // Pan from (north, east); its magnitude feeds the tilt vectoring.
    logic v4;
    t_vec horiz, u4, y4;
    t_ang pan;
    acp_cordic #(.STAGES(CORDIC_STAGES), .VECT(1'b1), .SW(W)) u_pan (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(v3),
        .i_x(n3), .i_y(e3), .i_z('0), .i_side(u3),
        .o_vld(v4), .o_x(horiz), .o_y(y4), .o_z(pan), .o_side(u4)
    );

    logic v5;
    t_vec x5, y5;
    t_ang tilt, pan5;
    acp_cordic #(.STAGES(CORDIC_STAGES), .VECT(1'b1), .SW(AW)) u_tilt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(v4),
        .i_x(horiz), .i_y(u4), .i_z('0), .i_side(pan),
        .o_vld(v5), .o_x(x5), .o_y(y5), .o_z(tilt), .o_side(pan5)
    );

    // Binary angle to 1/64 degree with rounding; a full turn wraps to zero.
    logic [47:0] r_pprod, r_tprod;
    logic r_vldd;
    logic [15:0] pan_q, tilt_q;
    logic r_oval;
    logic [14:0] r_pan, r_tilt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vldd <= 1'b0;
            r_oval <= 1'b0;
        end else begin
            r_vldd <= v5;
            r_oval <= r_vldd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pprod <= 48'(pan5) * 48'(acp_pkg::DEG64_TURN) + 48'h0000_8000_0000;
        r_tprod <= 48'(tilt) * 48'(acp_pkg::DEG64_TURN) + 48'h0000_8000_0000;
    end

    always_comb begin
        pan_q = r_pprod[47:32];
        tilt_q = r_tprod[47:32];
    end

    always_ff @(posedge i_clk) begin
        r_pan <= (pan_q >= 16'(acp_pkg::DEG64_TURN)) ? '0 : pan_q[14:0];
        r_tilt <= (tilt_q >= 16'(acp_pkg::DEG64_TURN)) ? '0 : tilt_q[14:0];
    end

    assign o_valid = r_oval;
    assign o_pan_deg = r_pan;
    assign o_tilt_deg = r_tilt;

    a_busy_low: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");
    a_out_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result without item");
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LAT o_valid)
        else $error("item lost");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pan_deg < acp_pkg::DEG64_TURN) && (o_tilt_deg < acp_pkg::DEG64_TURN))
        else $error("angle out of range");

endmodule
`default_nettype wire

FILE: tb/antenna_pan_tilt_pointing_test.sv
`default_nettype none
module antenna_pan_tilt_pointing_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES = acp_pkg::DEF_CORDIC_STAGES;
    localparam int LATENCY = 5 * (STAGES + 3) + 3;
    localparam logic [31:0] QUARTER = 32'h40000000;
    localparam logic [31:0] HALF = 32'h80000000;
    localparam logic [31:0] THREE_QUARTER = 32'hC0000000;
    localparam longint COMP_GAIN = 39797;

    localparam logic [31:0] ARCTAN [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic signed [23:0] own_east;
        logic signed [23:0] own_north;
        logic signed [23:0] own_alt;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic signed [23:0] tgt_east;
        logic signed [23:0] tgt_north;
        logic signed [23:0] tgt_alt;
    } t_fix;

    typedef struct packed {
        logic [14:0] pan;
        logic [14:0] tilt;
    } t_bearing;

    typedef struct {
        t_fix     fix;
        logic     known;
        t_bearing answer;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_fix cmd = '0;
    logic o_valid;
    logic [14:0] o_pan_deg, o_tilt_deg;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic i_cfg_data = 1'b0;

    logic heading_off = 1'b0;
    logic attitude_off = 1'b0;
    t_bearing pending_bearings[$];
    int mismatches = 0;
    int bearings_seen = 0;
    int fixes_sent = 0;

    always #5 i_clk = ~i_clk;

    antenna_pan_tilt_pointing dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_own_east(cmd.own_east), .i_own_north(cmd.own_north), .i_own_alt(cmd.own_alt),
        .i_roll_ang(cmd.roll), .i_pitch_ang(cmd.pitch), .i_yaw_ang(cmd.yaw),
        .i_target_east(cmd.tgt_east), .i_target_north(cmd.tgt_north),
        .i_target_alt(cmd.tgt_alt),
        .o_valid(o_valid), .o_pan_deg(o_pan_deg), .o_tilt_deg(o_tilt_deg),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    function automatic longint gain_fix(longint v);
        return (v * COMP_GAIN) >>> 16;
    endfunction

    // Counter-clockwise CORDIC rotation followed by fixed gain compensation.
    function automatic void rotate_pair(inout longint x, inout longint y,
                                        input logic [31:0] ang);
        logic [31:0] z;
        longint xs, ys;
        z = ang;
        if (((z + QUARTER) & HALF) != 0) begin
            x = -x;
            y = -y;
            z = z + HALF;
        end
        for (int i = 0; i < STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z[31]) begin
                x = x + ys; y = y - xs; z = z + ARCTAN[i];
            end else begin
                x = x - ys; y = y + xs; z = z - ARCTAN[i];
            end
        end
        x = gain_fix(x);
        y = gain_fix(y);
    endfunction

    function automatic void heading_of(input longint x_in, input longint y_in,
                                       output logic [31:0] ang, output longint mag);
        longint x, y, t, xs, ys;
        x = x_in;
        y = y_in;
        ang = '0;
        mag = 0;
        if (x != 0 || y != 0) begin
            if (x < 0) begin
                t = x;
                if (y >= 0) begin
                    x = y; y = -t; ang = QUARTER;
                end else begin
                    x = -y; y = t; ang = THREE_QUARTER;
                end
            end
            for (int i = 0; i < STAGES; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys; y = y - xs; ang = ang + ARCTAN[i];
                end else begin
                    x = x - ys; y = y + xs; ang = ang - ARCTAN[i];
                end
            end
            mag = gain_fix(x);
        end
    endfunction

    function automatic logic [14:0] to_sixty_fourths(logic [31:0] ang);
        logic [63:0] v;
        v = ({32'b0, ang} * 64'd23040 + 64'h80000000) >> 32;
        return (v >= 64'd23040) ? 15'd0 : v[14:0];
    endfunction

    function automatic t_bearing point_antenna(t_fix f);
        longint e, n, u, horiz, unused_mag;
        logic [31:0] roll_a, pitch_a, yaw_a, pan_a, tilt_a;
        t_bearing b;
        e = (longint'(f.tgt_east) - longint'(f.own_east)) <<< 20;
        n = (longint'(f.tgt_north) - longint'(f.own_north)) <<< 20;
        u = (longint'(f.tgt_alt) - longint'(f.own_alt)) <<< 20;
        roll_a = {f.roll, 16'h0};
        pitch_a = {f.pitch, 16'h0};
        yaw_a = {f.yaw, 16'h0};
        if (heading_off) yaw_a = '0;
        if (attitude_off) begin
            roll_a = '0;
            pitch_a = '0;
        end
        rotate_pair(n, e, 32'd0 - yaw_a);
        rotate_pair(n, u, 32'd0 - pitch_a);
        rotate_pair(e, u, roll_a);
        heading_of(n, e, pan_a, horiz);
        heading_of(horiz, u, tilt_a, unused_mag);
        b.pan = to_sixty_fourths(pan_a);
        b.tilt = to_sixty_fourths(tilt_a);
        return b;
    endfunction

    function automatic t_fix make_fix(int oe, int on, int oa, int r, int p, int y,
                                      int te, int tn, int ta);
        t_fix f;
        f.own_east = oe[23:0]; f.own_north = on[23:0]; f.own_alt = oa[23:0];
        f.roll = r[15:0]; f.pitch = p[15:0]; f.yaw = y[15:0];
        f.tgt_east = te[23:0]; f.tgt_north = tn[23:0]; f.tgt_alt = ta[23:0];
        return f;
    endfunction

    function automatic int short_gap();
        int roll_dice;
        roll_dice = $urandom_range(0, 99);
        if (roll_dice < 50) return 0;
        if (roll_dice < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Random fix: mostly nearby targets, sometimes full range, rarely coincident.
    function automatic t_fix random_fix();
        t_fix f;
        int kind;
        f = t_fix'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
            f.tgt_east = f.own_east + 24'($signed($urandom_range(0, 20000)) - 10000);
            f.tgt_north = f.own_north + 24'($signed($urandom_range(0, 20000)) - 10000);
            f.tgt_alt = f.own_alt + 24'($signed($urandom_range(0, 4000)) - 2000);
        end else if (kind == 6) begin
            f.tgt_east = f.own_east;
            f.tgt_north = f.own_north;
            f.tgt_alt = f.own_alt;
        end
        return f;
    endfunction

    task automatic send_fix(input t_fix f, input logic known, input t_bearing answer);
        int gap;
        cmd <= f;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        pending_bearings.push_back(known ? answer : point_antenna(f));
        fixes_sent++;
        gap = short_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic val);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == acp_pkg::CFG_IGNORE_HEADING) heading_off = val;
        else if (idx == acp_pkg::CFG_IGNORE_ATTITUDE) attitude_off = val;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_bearings.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_bearing want;
        if (i_rst_n && o_valid) begin
            bearings_seen++;
            if (pending_bearings.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result pan=%0d tilt=%0d",
                                               o_pan_deg, o_tilt_deg);
            end else begin
                want = pending_bearings.pop_front();
                if (o_pan_deg !== want.pan || o_tilt_deg !== want.tilt) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: pan exp %0d got %0d, tilt exp %0d got %0d",
                                 want.pan, o_pan_deg, want.tilt, o_tilt_deg);
                end
            end
        end
    end

    initial begin
        #10ms;
        $display("timeout");
        $display("antenna_pan_tilt_pointing_test NOT OK");
        $finish;
    end

    initial begin
        t_row rows[$];
        t_row r;
        t_bearing zero_b;
        logic [1:0] phase_cfg [5];
        zero_b = '0;
        phase_cfg = '{2'b00, 2'b01, 2'b10, 2'b11, 2'b00};

        // Coincident target and tracker gives zero pan and tilt for any attitude.
        r.known = 1'b1; r.answer = zero_b;
        r.fix = make_fix(0, 0, 0, 0, 0, 0, 0, 0, 0); rows.push_back(r);
        r.fix = make_fix(-8388608, 8388607, 123, 32767, -32768, 32767,
                         -8388608, 8388607, 123); rows.push_back(r);
        r.fix = make_fix(8388607, -8388608, -8388608, -32768, 32767, -32768,
                         8388607, -8388608, -8388608); rows.push_back(r);
        r.known = 1'b0;
        r.fix = make_fix(-8388608, -8388608, -8388608, 0, 0, 0,
                         8388607, 8388607, 8388607); rows.push_back(r);
        r.fix = make_fix(8388607, 8388607, 8388607, 0, 0, 0,
                         -8388608, -8388608, -8388608); rows.push_back(r);
        r.fix = make_fix(-8388608, 8388607, -8388608, 32767, 32767, 32767,
                         8388607, -8388608, 8388607); rows.push_back(r);
        r.fix = make_fix(0, 0, 0, -32768, -32768, -32768, 1, 1, 1); rows.push_back(r);
        r.fix = make_fix(0, 0, 0, 0, 0, 0, 0, 1000, 0); rows.push_back(r);
        r.fix = make_fix(0, 0, 0, 0, 0, 0, 1000, 0, 0); rows.push_back(r);
        r.fix = make_fix(0, 0, 0, 0, 0, 0, 0, -1000, 0); rows.push_back(r);
        r.fix = make_fix(0, 0, 0, 0, 0, 0, -1000, 0, 0); rows.push_back(r);
        r.fix = make_fix(0, 0, 0, 0, 0, 0, 0, 0, 1000); rows.push_back(r);
        r.fix = make_fix(0, 0, 0, 0, 0, 0, 0, 0, -1000); rows.push_back(r);
        r.fix = make_fix(0, 0, 0, 0, 0, 0, -1000, -1, 0); rows.push_back(r);
        r.fix = make_fix(0, 0, 0, 16384, -16384, 8192, 500, 700, -300); rows.push_back(r);
        r.fix = make_fix(100, 200, 300, -1, 1, -1, 101, 200, 300); rows.push_back(r);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) send_fix(rows[k].fix, rows[k].known, rows[k].answer);
        drain();

        foreach (phase_cfg[p]) begin
            write_reg(acp_pkg::CFG_IGNORE_HEADING, phase_cfg[p][0]);
            write_reg(acp_pkg::CFG_IGNORE_ATTITUDE, phase_cfg[p][1]);
            for (int k = 0; k < 150; k++) send_fix(random_fix(), 1'b0, zero_b);
            drain();
        end

        $display("sent %0d fixes over five register settings, checked %0d bearings",
                 fixes_sent, bearings_seen);
        if (mismatches == 0 && pending_bearings.size() == 0) begin
            $display("antenna_pan_tilt_pointing_test OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("antenna_pan_tilt_pointing_test NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire
